[rtl/rgbxf_pkg.sv]
// ----------------------------------------------------------------------------
// rgbxf_pkg
// Shared types and constants of the RGB16 alpha cross-fade block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbxf_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned CHAN_W     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = ALPHA_W;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [ALPHA_W-1:0]    alpha_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_ALPHA  = 1'b0;
  localparam cfg_idx_t CFG_FORMAT = 1'b1;

  typedef struct packed {
    alpha_t alpha;
    logic   is565;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/rgbxf_in_if.sv]
// ----------------------------------------------------------------------------
// rgbxf_in_if
// Input channel: background and foreground pixel with end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbxf_in_if;
  logic              valid;
  logic              ready;
  rgbxf_pkg::pix_t   background_pixel;
  rgbxf_pkg::pix_t   foreground_pixel;
  logic              last_in;

  modport source (output valid, output background_pixel, output foreground_pixel,
                  output last_in, input ready);
  modport sink   (input valid, input background_pixel, input foreground_pixel,
                  input last_in, output ready);
endinterface

`default_nettype wire

[rtl/rgbxf_out_if.sv]
// ----------------------------------------------------------------------------
// rgbxf_out_if
// Result channel: blended pixel with end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbxf_out_if;
  logic              valid;
  logic              ready;
  rgbxf_pkg::pix_t   blended_pixel;
  logic              last_out;

  modport source (output valid, output blended_pixel, output last_out, input ready);
  modport sink   (input valid, input blended_pixel, input last_out, output ready);
endinterface

`default_nettype wire

[rtl/rgbxf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rgbxf_cfg_regs
// Configuration registers: blend weight and pixel format select.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbxf_cfg_regs (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  rgbxf_pkg::cfg_idx_t  cfg_index,
  input  rgbxf_pkg::cfg_data_t cfg_wdata,
  output rgbxf_pkg::cfg_t      cfg
);

  rgbxf_pkg::cfg_t cfg_r;
  rgbxf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rgbxf_pkg::CFG_ALPHA:  cfg_nxt.alpha = cfg_wdata[rgbxf_pkg::ALPHA_W-1:0];
        rgbxf_pkg::CFG_FORMAT: cfg_nxt.is565 = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha <= '0;
      cfg_r.is565 <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/rgbxf_mix_chan.sv]
// ----------------------------------------------------------------------------
// rgbxf_mix_chan
// One colour channel: weighted background plus weighted foreground.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbxf_mix_chan (
  input  rgbxf_pkg::alpha_t alpha,
  input  rgbxf_pkg::chan_t  bg,
  input  rgbxf_pkg::chan_t  fg,
  output rgbxf_pkg::chan_t  mix
);

  localparam int unsigned PROD_W = rgbxf_pkg::ALPHA_W + rgbxf_pkg::CHAN_W;

  rgbxf_pkg::alpha_t       inv;
  logic [PROD_W-1:0]       bg_prod;
  logic [PROD_W-1:0]       fg_prod;
  logic [rgbxf_pkg::CHAN_W:0] sum;

  always_comb begin
    inv     = rgbxf_pkg::ALPHA_MAX - alpha;
    bg_prod = PROD_W'(inv) * PROD_W'(bg);
    fg_prod = PROD_W'(alpha) * PROD_W'(fg);
    sum     = {1'b0, bg_prod[PROD_W-1 -: rgbxf_pkg::CHAN_W]}
            + {1'b0, fg_prod[PROD_W-1 -: rgbxf_pkg::CHAN_W]}
            + (rgbxf_pkg::CHAN_W+1)'(1);
    mix     = sum[rgbxf_pkg::CHAN_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/rgbxf_blend.sv]
// ----------------------------------------------------------------------------
// rgbxf_blend
// Pixel blend: unpack both pixels, mix three channels, repack.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbxf_blend (
  input  rgbxf_pkg::cfg_t cfg,
  input  rgbxf_pkg::pix_t bg_pix,
  input  rgbxf_pkg::pix_t fg_pix,
  output rgbxf_pkg::pix_t out_pix
);

  rgbxf_pkg::chan_t bg_r, bg_g, bg_b;
  rgbxf_pkg::chan_t fg_r, fg_g, fg_b;
  rgbxf_pkg::chan_t mx_r, mx_g, mx_b;

  always_comb begin
    bg_b = {1'b0, bg_pix[4:0]};
    fg_b = {1'b0, fg_pix[4:0]};
    if (cfg.is565) begin
      bg_g = bg_pix[10:5];
      fg_g = fg_pix[10:5];
      bg_r = {1'b0, bg_pix[15:11]};
      fg_r = {1'b0, fg_pix[15:11]};
    end else begin
      bg_g = {1'b0, bg_pix[9:5]};
      fg_g = {1'b0, fg_pix[9:5]};
      bg_r = {1'b0, bg_pix[14:10]};
      fg_r = {1'b0, fg_pix[14:10]};
    end
  end

  rgbxf_mix_chan u_mix_r (.alpha(cfg.alpha), .bg(bg_r), .fg(fg_r), .mix(mx_r));
  rgbxf_mix_chan u_mix_g (.alpha(cfg.alpha), .bg(bg_g), .fg(fg_g), .mix(mx_g));
  rgbxf_mix_chan u_mix_b (.alpha(cfg.alpha), .bg(bg_b), .fg(fg_b), .mix(mx_b));

  always_comb begin
    if (cfg.is565) begin
      out_pix = {mx_r[4:0], mx_g[5:0], mx_b[4:0]};
    end else begin
      out_pix = {1'b0, mx_r[4:0], mx_g[4:0], mx_b[4:0]};
    end
  end

endmodule

`default_nettype wire

[rtl/rgb16_alpha_crossfade.sv]
// ----------------------------------------------------------------------------
// rgb16_alpha_crossfade
// Cross-fade of two RGB565 / RGB555 pixels with a programmable alpha.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    background_pixel, foreground_pixel, last_in
//  out_ch    out   valid / ready    blended_pixel, last_out
//  cfg_*     in    cfg_we           cfg_index, cfg_wdata
//
//  One item per cycle while out_ch does not stall; path: input register, then result register.
//  The cycle is set by the six 8x6 multipliers between the two registers.
//  Reset clears both valid flags, alpha to 0 and the format to RGB565.
//  A stall on out_ch holds the result; in_ch still takes an item while the
//  input register is empty or moving on.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb16_alpha_crossfade (
  input  wire                  clk,
  input  wire                  rst_n,
  rgbxf_in_if.sink             in_ch,
  rgbxf_out_if.source          out_ch,
  input  wire                  cfg_we,
  input  rgbxf_pkg::cfg_idx_t  cfg_index,
  input  rgbxf_pkg::cfg_data_t cfg_wdata
);

  rgbxf_pkg::cfg_t cfg;

  logic            s1_vld_r, s1_vld_nxt;
  rgbxf_pkg::pix_t s1_bg_r, s1_fg_r;
  logic            s1_last_r;

  logic            s2_vld_r, s2_vld_nxt;
  rgbxf_pkg::pix_t s2_pix_r;
  logic            s2_last_r;

  rgbxf_pkg::pix_t mix_pix;
  logic            s2_adv;
  logic            s1_adv;

  rgbxf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rgbxf_blend u_blend (
    .cfg     (cfg),
    .bg_pix  (s1_bg_r),
    .fg_pix  (s1_fg_r),
    .out_pix (mix_pix)
  );

  assign s2_adv = !s2_vld_r || out_ch.ready;
  assign s1_adv = !s1_vld_r || s2_adv;

  assign in_ch.ready = s1_adv;

  assign s1_vld_nxt = s1_adv ? in_ch.valid : s1_vld_r;
  assign s2_vld_nxt = s2_adv ? s1_vld_r : s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // advance payload only with an item
  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_bg_r   <= in_ch.background_pixel;
      s1_fg_r   <= in_ch.foreground_pixel;
      s1_last_r <= in_ch.last_in;
    end
    if (s2_adv && s1_vld_r) begin
      s2_pix_r  <= mix_pix;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid         = s2_vld_r;
  assign out_ch.blended_pixel = s2_pix_r;
  assign out_ch.last_out      = s2_last_r;

`ifndef SYNTHESIS
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_ch.valid || out_ch.ready) |-> in_ch.ready)
    else $error("input refused while output side free");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_vld_r)
    else $error("accepted item lost from input register");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s2_adv) |=> (s1_vld_r && $stable(s1_bg_r) && $stable(s1_fg_r)))
    else $error("input register changed during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
